// ----- rtl/fsl_pkg.sv -----
// ============================================================================
// fsl_pkg
// Shared widths, reset values and codes of the free-list slot allocator.
// ============================================================================
`default_nettype none

package fsl_pkg;

    localparam int POOL_DEPTH_DEF = 1024;

    localparam int ADDR_W   = 48;
    localparam int STRIDE_W = 9;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 9'd32;
    localparam logic [COUNT_W-1:0]  SLOT_COUNT_RST  = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_HEAP_BASE = 2'd0,
        CFG_GPU_HEAP_BASE = 2'd1,
        CFG_SLOT_STRIDE   = 2'd2,
        CFG_SLOT_COUNT    = 2'd3
    } t_cfg_idx;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/fsl_req_if.sv -----
// ============================================================================
// fsl_req_if
// Request channel of the slot allocator: valid/ready and the request fields.
// ============================================================================
`default_nettype none

interface fsl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic                        handle_present;
    logic [fsl_pkg::ADDR_W-1:0]  freed_cpu_address;

    modport source (output valid, output operation, output handle_present,
                    output freed_cpu_address, input ready);
    modport sink   (input valid, input operation, input handle_present,
                    input freed_cpu_address, output ready);
endinterface

`default_nettype wire

// ----- rtl/fsl_rsp_if.sv -----
// ============================================================================
// fsl_rsp_if
// Response channel of the slot allocator: valid/ready and the result fields.
// ============================================================================
`default_nettype none

interface fsl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsl_pkg::ADDR_W-1:0]    cpu_address;
    logic [fsl_pkg::ADDR_W-1:0]    gpu_address;
    logic [fsl_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output cpu_address, output gpu_address,
                    output status, input ready);
    modport sink   (input valid, input cpu_address, input gpu_address,
                    input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/free_list_slot_allocator.sv -----
// ============================================================================
// free_list_slot_allocator
// Fixed pool of slots handed out from a stack of free slot indices.
// ============================================================================
// Usage:
//   Requests arrive on i_req (valid/ready). An allocate request pops the next
//   free index and returns base + index * stride for the CPU and GPU heaps
//   (zero where a base is zero). A free request maps a CPU address back to an
//   index and pushes it. Every request produces exactly one response on o_rsp.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Sequencing:
//   One request is in work at a time; i_req.ready is high only when idle.
//   An allocate passes S_ARD, S_AMUL and S_AADD and a free passes S_FCHK,
//   S_FDIV and S_FPUSH; then S_OUT loads the response and raises o_rsp.valid.
//   A request rejected on arrival goes straight to S_OUT, and a free whose
//   address is out of range leaves from S_FCHK. S_FDIV runs the bit-serial
//   divider, one quotient bit per cycle. The next request is taken once the
//   block is back in S_IDLE after the response has been loaded.
// Reset:
//   The stack reads back in identity order and the head is zero. No clearing
//   pass is needed: a high-water mark tells which stack entries were written.
// Back-pressure:
//   The response sits in an output register; the block finishes the next
//   request into a holding register and waits there while o_rsp is stalled.
// ============================================================================
`default_nettype none

module free_list_slot_allocator #(
    parameter int POOL_DEPTH = fsl_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fsl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fsl_pkg::ADDR_W-1:0]        i_cfg_data,
    fsl_req_if.sink                                i_req,
    fsl_rsp_if.source                              o_rsp
);

    localparam int ADDR_W   = fsl_pkg::ADDR_W;
    localparam int STRIDE_W = fsl_pkg::STRIDE_W;
    localparam int COUNT_W  = fsl_pkg::COUNT_W;
    localparam int STATUS_W = fsl_pkg::STATUS_W;
    localparam int IDX_W    = $clog2(POOL_DEPTH);
    localparam int HEAD_W   = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W    = (HEAD_W > COUNT_W) ? HEAD_W : COUNT_W;
    localparam int LIM_W    = HEAD_W + STRIDE_W;
    localparam int DIV_W    = IDX_W + STRIDE_W;
    localparam int CNT_W    = $clog2(IDX_W + 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(POOL_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ARD   = 8'b0000_0010,
        S_AMUL  = 8'b0000_0100,
        S_AADD  = 8'b0000_1000,
        S_FCHK  = 8'b0001_0000,
        S_FDIV  = 8'b0010_0000,
        S_FPUSH = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_cpu_base, n_cpu_base;
    logic [ADDR_W-1:0]     r_gpu_base, n_gpu_base;
    logic [STRIDE_W-1:0]   r_slot_stride, n_slot_stride;
    logic [COUNT_W-1:0]    r_slot_count, n_slot_count;
    logic [HEAD_W-1:0]     r_head, n_head;
    logic [HEAD_W-1:0]     r_high, n_high;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [DIV_W-1:0]      r_prod, n_prod;
    logic [ADDR_W-1:0]     r_offset, n_offset;
    logic [LIM_W-1:0]      r_limit, n_limit;
    logic [STRIDE_W-1:0]   r_rem, n_rem;
    logic [IDX_W-1:0]      r_dq, n_dq;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ADDR_W-1:0]     r_res_cpu, n_res_cpu;
    logic [ADDR_W-1:0]     r_res_gpu, n_res_gpu;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]     r_out_cpu, n_out_cpu;
    logic [ADDR_W-1:0]     r_out_gpu, n_out_gpu;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    logic [CMP_W-1:0]      w_count_ext;
    logic [HEAD_W-1:0]     w_eff;
    logic [HEAD_W-1:0]     w_head_inc;
    logic [HEAD_W-1:0]     w_head_dec;
    logic [STRIDE_W:0]     w_div_t;
    logic [STRIDE_W:0]     w_div_d;
    logic                  w_div_ge;
    logic                  w_ram_we;
    logic [IDX_W-1:0]      w_rdata;

    // Effective slot count is the configured count clamped to the built depth.
    assign w_count_ext = CMP_W'(r_slot_count);
    assign w_eff       = (w_count_ext > DEPTH_CMP) ? HEAD_W'(DEPTH_CMP)
                                                   : HEAD_W'(w_count_ext);
    assign w_head_inc  = r_head + 1'b1;
    assign w_head_dec  = r_head - 1'b1;

    // One restoring-division step: bring down the next dividend bit.
    assign w_div_t  = {r_rem, r_dq[IDX_W-1]};
    assign w_div_d  = {1'b0, r_slot_stride};
    assign w_div_ge = (w_div_t >= w_div_d);

    assign w_ram_we = (r_state == S_FPUSH);

    fsl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_head_dec[IDX_W-1:0]),
        .i_wdata (r_dq),
        .i_raddr (r_head[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.cpu_address = r_out_cpu;
    assign o_rsp.gpu_address = r_out_gpu;
    assign o_rsp.status      = r_out_status;

    always_comb begin
        n_state       = r_state;
        n_cpu_base    = r_cpu_base;
        n_gpu_base    = r_gpu_base;
        n_slot_stride = r_slot_stride;
        n_slot_count  = r_slot_count;
        n_head        = r_head;
        n_high        = r_high;
        n_idx         = r_idx;
        n_prod        = r_prod;
        n_offset      = r_offset;
        n_limit       = r_limit;
        n_rem         = r_rem;
        n_dq          = r_dq;
        n_cnt         = r_cnt;
        n_res_cpu     = r_res_cpu;
        n_res_gpu     = r_res_gpu;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_cpu     = r_out_cpu;
        n_out_gpu     = r_out_gpu;
        n_out_status  = r_out_status;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                fsl_pkg::CFG_CPU_HEAP_BASE: n_cpu_base    = i_cfg_data[ADDR_W-1:0];
                fsl_pkg::CFG_GPU_HEAP_BASE: n_gpu_base    = i_cfg_data[ADDR_W-1:0];
                fsl_pkg::CFG_SLOT_STRIDE:   n_slot_stride = i_cfg_data[STRIDE_W-1:0];
                fsl_pkg::CFG_SLOT_COUNT:    n_slot_count  = i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_cpu = '0;
                    n_res_gpu = '0;
                    if (i_req.operation == fsl_pkg::OP_ALLOC) begin
                        if (r_head >= w_eff) begin
                            n_res_status = fsl_pkg::ST_EXHAUSTED;
                            n_state      = S_OUT;
                        end else begin
                            // The RAM reads the head entry at this edge.
                            n_state = S_ARD;
                        end
                    end else if (!i_req.handle_present) begin
                        n_res_status = fsl_pkg::ST_IGNORED;
                        n_state      = S_OUT;
                    end else if (r_head == '0) begin
                        n_res_status = fsl_pkg::ST_EMPTY;
                        n_state      = S_OUT;
                    end else if (r_slot_stride == '0) begin
                        n_res_status = fsl_pkg::ST_IGNORED;
                        n_state      = S_OUT;
                    end else begin
                        // The quotient is in range exactly when the offset is
                        // below count * stride, so that product gates the divide.
                        n_offset = i_req.freed_cpu_address - r_cpu_base;
                        n_limit  = LIM_W'(w_eff) * LIM_W'(r_slot_stride);
                        n_state  = S_FCHK;
                    end
                end
            end
            S_ARD: begin
                // Entries at or above the high-water mark were never written
                // and still hold their reset value, which is their position.
                n_idx  = (r_head < r_high) ? w_rdata : r_head[IDX_W-1:0];
                n_head = w_head_inc;
                if (w_head_inc > r_high) begin
                    n_high = w_head_inc;
                end
                n_state = S_AMUL;
            end
            S_AMUL: begin
                n_prod  = DIV_W'(r_idx) * DIV_W'(r_slot_stride);
                n_state = S_AADD;
            end
            S_AADD: begin
                n_res_cpu    = (r_cpu_base == '0) ? '0 : r_cpu_base + ADDR_W'(r_prod);
                n_res_gpu    = (r_gpu_base == '0) ? '0 : r_gpu_base + ADDR_W'(r_prod);
                n_res_status = fsl_pkg::ST_DONE;
                n_state      = S_OUT;
            end
            S_FCHK: begin
                if (r_offset >= ADDR_W'(r_limit)) begin
                    n_res_status = fsl_pkg::ST_IGNORED;
                    n_state      = S_OUT;
                end else begin
                    n_rem   = r_offset[DIV_W-1:IDX_W];
                    n_dq    = r_offset[IDX_W-1:0];
                    n_cnt   = CNT_W'(IDX_W);
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                n_rem = w_div_ge ? STRIDE_W'(w_div_t - w_div_d) : w_div_t[STRIDE_W-1:0];
                n_dq  = {r_dq[IDX_W-2:0], w_div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_FPUSH;
                end
            end
            S_FPUSH: begin
                n_head       = w_head_dec;
                n_res_status = fsl_pkg::ST_DONE;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_cpu    = r_res_cpu;
                    n_out_gpu    = r_res_gpu;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cpu_base    <= '0;
            r_gpu_base    <= '0;
            r_slot_stride <= fsl_pkg::SLOT_STRIDE_RST;
            r_slot_count  <= fsl_pkg::SLOT_COUNT_RST;
            r_head        <= '0;
            r_high        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cpu_base    <= n_cpu_base;
            r_gpu_base    <= n_gpu_base;
            r_slot_stride <= n_slot_stride;
            r_slot_count  <= n_slot_count;
            r_head        <= n_head;
            r_high        <= n_high;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_offset     <= n_offset;
        r_limit      <= n_limit;
        r_rem        <= n_rem;
        r_dq         <= n_dq;
        r_cnt        <= n_cnt;
        r_res_cpu    <= n_res_cpu;
        r_res_gpu    <= n_res_gpu;
        r_res_status <= n_res_status;
        r_out_cpu    <= n_out_cpu;
        r_out_gpu    <= n_out_gpu;
        r_out_status <= n_out_status;
    end

`ifndef SYNTHESIS
    a_head_below_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_high)
        else $error("stack head above the high-water mark");

    a_mark_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high <= HEAD_W'(POOL_DEPTH))
        else $error("high-water mark beyond the pool depth");

    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ARD) |-> (r_head < w_eff))
        else $error("pop issued with the pool exhausted");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FPUSH) |-> (r_head != '0))
        else $error("push issued with nothing allocated");

    a_push_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FPUSH) |-> (HEAD_W'(r_dq) < w_eff))
        else $error("divider produced an index outside the pool");
`endif

endmodule

`default_nettype wire

// ----- rtl/fsl_ram.sv -----
// ============================================================================
// fsl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module fsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
